// ----- src/cpt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Shared types, widths and codes for the closest-point-on-triangle pipeline.
// No dependencies; imported by cpt_div, closest_point_on_triangle_top and tb_top.
package cpt_pkg;

    // Coordinate width. The binary point cancels from every test and ratio.
    localparam int CW   = 32;
    localparam int DFW  = CW + 1;           // vertex differences
    localparam int PW   = 2 * DFW;          // one coordinate product
    localparam int KW   = PW + 2;           // dot products k1..k6
    localparam int KC   = KW / 2;           // k split for the cross products
    localparam int KPW  = 2 * KC;
    localparam int GPW  = 2 * KW;           // k * k product
    localparam int GW   = GPW + 2;          // cross terms ga, gb, gc
    localparam int EW   = KW + 2;           // k differences, edge denominators
    localparam int DW   = GW + 2;           // any denominator
    localparam int MW   = GW;               // wide multiplier operand
    localparam int MC   = 28;               // chunk of the wide operand
    localparam int NCH  = (MW + MC - 1) / MC;
    localparam int MEW  = NCH * MC;
    localparam int PPW  = DFW + MC + 1;     // one partial product
    localparam int NW   = DFW + MW + 3;     // numerator
    localparam int XW   = NW + 2;           // 2*num + den
    localparam int UW   = XW - 1;           // folded dividend magnitude
    localparam int YW   = DW + 1;           // 2*den
    localparam int QB   = CW + 2;           // quotient bits kept
    localparam int SW   = QB + 2;           // base + offset before saturation

    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    // dot product indexes
    localparam int K1 = 0;
    localparam int K2 = 1;
    localparam int K3 = 2;
    localparam int K4 = 3;
    localparam int K5 = 4;
    localparam int K6 = 5;
    // cross term indexes
    localparam int GA = 0;
    localparam int GB = 1;
    localparam int GC = 2;

    typedef enum logic [2:0] {
        REG_A  = 3'd0,
        REG_B  = 3'd1,
        REG_AB = 3'd2,
        REG_C  = 3'd3,
        REG_AC = 3'd4,
        REG_BC = 3'd5,
        REG_IN = 3'd6
    } t_region;

    typedef struct packed {
        logic    use_base;
        logic    degen;
        t_region region;
    } t_sel;

    typedef struct packed {
        logic signed [CW-1:0] query_x;
        logic signed [CW-1:0] query_y;
        logic signed [CW-1:0] query_z;
        logic signed [CW-1:0] vert_a_x;
        logic signed [CW-1:0] vert_a_y;
        logic signed [CW-1:0] vert_a_z;
        logic signed [CW-1:0] vert_b_x;
        logic signed [CW-1:0] vert_b_y;
        logic signed [CW-1:0] vert_b_z;
        logic signed [CW-1:0] vert_c_x;
        logic signed [CW-1:0] vert_c_y;
        logic signed [CW-1:0] vert_c_z;
    } t_in_item;

    typedef struct packed {
        logic signed [CW-1:0] near_x;
        logic signed [CW-1:0] near_y;
        logic signed [CW-1:0] near_z;
        logic [2:0]           region;
        logic                 degenerate;
    } t_out_item;

    typedef struct packed {
        logic [2:0][CW-1:0]  a;
        logic [2:0][CW-1:0]  b;
        logic [2:0][CW-1:0]  c;
        logic [2:0][DFW-1:0] eab;
        logic [2:0][DFW-1:0] eac;
        logic [2:0][DFW-1:0] ebc;
    } t_geo;

endpackage
`default_nettype wire

// ----- src/cpt_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Pipelined floor divider and output stage: one quotient bit per stage,
// base add and saturation. Depends on cpt_pkg.
module cpt_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_vld,
    input  wire cpt_pkg::t_sel                 i_sel,
    input  wire logic signed [cpt_pkg::XW-1:0] i_x [3],
    input  wire logic [cpt_pkg::YW-1:0]        i_y,
    input  wire logic signed [cpt_pkg::CW-1:0] i_base [3],
    output logic                               o_vld,
    output cpt_pkg::t_out_item                 o_res
);
    import cpt_pkg::*;

    logic [UW-1:0]        w_u [3];
    logic                 w_ovf [3];
    logic [QB:0]          r_vld;
    logic [UW-1:0]        r_rem [QB+1][3];
    logic [QB-1:0]        r_q [QB+1][3];
    logic [YW-1:0]        r_y [QB];
    logic                 r_neg [QB+1][3];
    logic                 r_ovf [QB+1][3];
    t_sel                 r_sel [QB+1];
    logic signed [CW-1:0] r_base [QB+1][3];
    logic signed [SW-1:0] w_qs [3];
    logic signed [SW-1:0] w_off [3];
    logic signed [SW-1:0] w_sum [3];
    logic signed [CW-1:0] w_near [3];
    t_out_item            n_res;
    t_out_item            r_res;
    logic                 r_ovld;

    // floor(X/Y) for X < 0 is ~floor(~X/Y): fold to a magnitude
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_u[i]   = i_x[i][XW-1] ? UW'(~i_x[i]) : UW'(i_x[i]);
            w_ovf[i] = (w_u[i] >= {i_y, {QB{1'b0}}});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else begin
            r_vld  <= {r_vld[QB-1:0], i_vld};
            r_ovld <= r_vld[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_rem[0][i]  <= w_u[i];
            r_q[0][i]    <= '0;
            r_neg[0][i]  <= i_x[i][XW-1];
            r_ovf[0][i]  <= w_ovf[i];
            r_base[0][i] <= i_base[i];
        end
        r_y[0]   <= i_y;
        r_sel[0] <= i_sel;
        for (int s = 0; s < QB; s++) begin
            for (int i = 0; i < 3; i++) begin
                if (r_rem[s][i] >= (UW'(r_y[s]) << (QB-1-s))) begin
                    r_rem[s+1][i] <= r_rem[s][i] - (UW'(r_y[s]) << (QB-1-s));
                    r_q[s+1][i]   <= r_q[s][i] | (QB'(1) << (QB-1-s));
                end else begin
                    r_rem[s+1][i] <= r_rem[s][i];
                    r_q[s+1][i]   <= r_q[s][i];
                end
                r_neg[s+1][i]  <= r_neg[s][i];
                r_ovf[s+1][i]  <= r_ovf[s][i];
                r_base[s+1][i] <= r_base[s][i];
            end
            if (s < QB-1) begin
                r_y[s+1] <= r_y[s];
            end
            r_sel[s+1] <= r_sel[s];
        end
        r_res <= n_res;
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_qs[i]  = {2'b00, r_q[QB][i]};
            w_off[i] = r_neg[QB][i] ? ~w_qs[i] : w_qs[i];
            w_sum[i] = SW'(r_base[QB][i]) + w_off[i];
            priority if (r_sel[QB].use_base) begin
                w_near[i] = r_base[QB][i];
            end else if (r_ovf[QB][i]) begin
                w_near[i] = r_neg[QB][i] ? CMIN : CMAX;
            end else if (w_sum[i] > SW'(CMAX)) begin
                w_near[i] = CMAX;
            end else if (w_sum[i] < SW'(CMIN)) begin
                w_near[i] = CMIN;
            end else begin
                w_near[i] = CW'(w_sum[i]);
            end
        end
        n_res.near_x     = w_near[0];
        n_res.near_y     = w_near[1];
        n_res.near_z     = w_near[2];
        n_res.region     = r_sel[QB].region;
        n_res.degenerate = r_sel[QB].degen;
    end

    assign o_vld = r_ovld;
    assign o_res = r_res;

endmodule
`default_nettype wire

// ----- src/closest_point_on_triangle_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Closest point on a triangle, Voronoi region tests, fully pipelined.
// Throughput: one item per clock; o_busy stays low.
// o_done rises once the item has passed the 11 front-end stages, 1 fold stage,
// 34 quotient-bit stages and the output reg.
// The long tail is the restoring divider, one quotient bit per stage.
// Reset (sync, active low) clears only the valid bits; no state is carried.
module closest_point_on_triangle_top (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire cpt_pkg::t_in_item    i_item,
    output logic                      o_busy,
    output logic                      o_done,
    output cpt_pkg::t_out_item        o_result
);
    import cpt_pkg::*;

    // operand pairs of the six k*k products:
    // gc = k1*k4 - k3*k2, gb = k5*k2 - k1*k6, ga = k3*k6 - k5*k4
    localparam int GPA [6] = '{K1, K3, K5, K1, K3, K5};
    localparam int GPB [6] = '{K4, K2, K2, K6, K6, K4};

    logic                    w_acc;
    logic [10:0]             r_vld;

    // stage 0: input register
    t_in_item                r0_item;
    logic signed [CW-1:0]    w_p [3];
    logic signed [CW-1:0]    w_a [3];
    logic signed [CW-1:0]    w_b [3];
    logic signed [CW-1:0]    w_c [3];

    // stage 1: differences
    t_geo                    r_geo [1:6];
    logic signed [DFW-1:0]   r1_rp [3];
    logic signed [DFW-1:0]   r1_rq [3];
    logic signed [DFW-1:0]   r1_rc [3];

    // stage 2: coordinate products
    logic signed [DFW-1:0]   w2_u [6][3];
    logic signed [DFW-1:0]   w2_v [6][3];
    logic signed [PW-1:0]    r2_pr [6][3];

    // stage 3..6: dot products carried along
    logic signed [KW-1:0]    r_k [3:6][6];

    // stage 4: partial products of k*k
    logic signed [KPW-1:0]   r4_hh [6];
    logic signed [KPW:0]     r4_hl [6];
    logic signed [KPW:0]     r4_lh [6];
    logic [KPW-1:0]          r4_ll [6];

    // stage 5: k*k products
    logic signed [GPW-1:0]   r5_gp [6];

    // stage 6: cross terms and k differences
    logic signed [GW-1:0]    r6_g [3];
    logic signed [EW-1:0]    r6_e43;
    logic signed [EW-1:0]    r6_e56;
    logic signed [EW-1:0]    r6_dab;
    logic signed [EW-1:0]    r6_dac;
    logic signed [EW-1:0]    r6_dbc;

    // stage 7: region select
    logic                    w_k_le0 [6];
    logic                    w_g_le0 [3];
    logic                    w_e43_le0;
    logic                    w_e56_le0;
    logic signed [DW-1:0]    w_dint;
    t_sel                    n_sel;
    logic signed [CW-1:0]    n_base [3];
    logic signed [DFW-1:0]   n_u [2][3];
    logic signed [MW-1:0]    n_m [2];
    logic signed [DW-1:0]    n_den;
    t_sel                    r_sel [7:10];
    logic signed [CW-1:0]    r_base [7:10][3];
    logic signed [DW-1:0]    r_den [7:9];
    logic signed [DFW-1:0]   r7_u [2][3];
    logic signed [MW-1:0]    r7_m [2];

    // stage 8: chunked products for the numerator
    logic signed [MEW-1:0]   w_me [2];
    logic signed [MC:0]      w_ch [2][NCH];
    logic signed [PPW-1:0]   r8_pp [3][2][NCH];

    // stage 9: numerator terms
    logic signed [NW-1:0]    n_t [3][2];
    logic signed [NW-1:0]    r9_t [3][2];

    // stage 10: rounding dividend and divisor
    logic signed [XW-1:0]    r10_x [3];
    logic [YW-1:0]           r10_y;

    // an item is taken whenever i_start is high
    assign o_busy = 1'b0;
    assign w_acc  = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[9:0], w_acc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r0_item <= i_item;
        end
    end

    assign w_p = '{r0_item.query_x,  r0_item.query_y,  r0_item.query_z};
    assign w_a = '{r0_item.vert_a_x, r0_item.vert_a_y, r0_item.vert_a_z};
    assign w_b = '{r0_item.vert_b_x, r0_item.vert_b_y, r0_item.vert_b_z};
    assign w_c = '{r0_item.vert_c_x, r0_item.vert_c_y, r0_item.vert_c_z};

    // dot product j: (eab for even j, eac for odd j) . (rp, rq, rc for j/2)
    always_comb begin
        for (int j = 0; j < 6; j++) begin
            for (int i = 0; i < 3; i++) begin
                w2_u[j][i] = (j % 2 == 0) ? $signed(r_geo[1].eab[i])
                                          : $signed(r_geo[1].eac[i]);
                if (j < 2) begin
                    w2_v[j][i] = r1_rp[i];
                end else if (j < 4) begin
                    w2_v[j][i] = r1_rq[i];
                end else begin
                    w2_v[j][i] = r1_rc[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // stage 1
        for (int i = 0; i < 3; i++) begin
            r_geo[1].a[i]   <= w_a[i];
            r_geo[1].b[i]   <= w_b[i];
            r_geo[1].c[i]   <= w_c[i];
            r_geo[1].eab[i] <= DFW'(w_b[i]) - DFW'(w_a[i]);
            r_geo[1].eac[i] <= DFW'(w_c[i]) - DFW'(w_a[i]);
            r_geo[1].ebc[i] <= DFW'(w_c[i]) - DFW'(w_b[i]);
            r1_rp[i]        <= DFW'(w_p[i]) - DFW'(w_a[i]);
            r1_rq[i]        <= DFW'(w_p[i]) - DFW'(w_b[i]);
            r1_rc[i]        <= DFW'(w_p[i]) - DFW'(w_c[i]);
        end
        for (int s = 2; s <= 6; s++) begin
            r_geo[s] <= r_geo[s-1];
        end

        // stage 2
        for (int j = 0; j < 6; j++) begin
            for (int i = 0; i < 3; i++) begin
                r2_pr[j][i] <= PW'(w2_u[j][i]) * PW'(w2_v[j][i]);
            end
        end

        // stage 3
        for (int j = 0; j < 6; j++) begin
            r_k[3][j] <= KW'(r2_pr[j][0]) + KW'(r2_pr[j][1]) + KW'(r2_pr[j][2]);
        end

        // stage 4: signed high half, unsigned low half
        for (int j = 0; j < 6; j++) begin
            r4_hh[j] <= KPW'($signed(r_k[3][GPA[j]][KW-1:KC]))
                      * KPW'($signed(r_k[3][GPB[j]][KW-1:KC]));
            r4_hl[j] <= (KPW+1)'($signed(r_k[3][GPA[j]][KW-1:KC]))
                      * (KPW+1)'($signed({1'b0, r_k[3][GPB[j]][KC-1:0]}));
            r4_lh[j] <= (KPW+1)'($signed({1'b0, r_k[3][GPA[j]][KC-1:0]}))
                      * (KPW+1)'($signed(r_k[3][GPB[j]][KW-1:KC]));
            r4_ll[j] <= KPW'(r_k[3][GPA[j]][KC-1:0]) * KPW'(r_k[3][GPB[j]][KC-1:0]);
        end
        for (int s = 4; s <= 6; s++) begin
            r_k[s] <= r_k[s-1];
        end

        // stage 5
        for (int j = 0; j < 6; j++) begin
            r5_gp[j] <= (GPW'(r4_hh[j]) <<< KPW)
                      + ((GPW'(r4_hl[j]) + GPW'(r4_lh[j])) <<< KC)
                      + $signed(GPW'(r4_ll[j]));
        end

        // stage 6
        r6_g[GC] <= GW'(r5_gp[0]) - GW'(r5_gp[1]);
        r6_g[GB] <= GW'(r5_gp[2]) - GW'(r5_gp[3]);
        r6_g[GA] <= GW'(r5_gp[4]) - GW'(r5_gp[5]);
        r6_e43   <= EW'(r_k[5][K4]) - EW'(r_k[5][K3]);
        r6_e56   <= EW'(r_k[5][K5]) - EW'(r_k[5][K6]);
        r6_dab   <= EW'(r_k[5][K1]) - EW'(r_k[5][K3]);
        r6_dac   <= EW'(r_k[5][K2]) - EW'(r_k[5][K6]);
        r6_dbc   <= EW'(r_k[5][K4]) - EW'(r_k[5][K3])
                  + EW'(r_k[5][K5]) - EW'(r_k[5][K6]);

        // stage 7
        r_sel[7]  <= n_sel;
        r_den[7]  <= n_den;
        r7_u      <= n_u;
        r7_m      <= n_m;
        r_base[7] <= n_base;

        // stage 8
        for (int i = 0; i < 3; i++) begin
            for (int t = 0; t < 2; t++) begin
                for (int c = 0; c < NCH; c++) begin
                    r8_pp[i][t][c] <= PPW'(r7_u[t][i]) * PPW'(w_ch[t][c]);
                end
            end
        end

        // stage 9
        r9_t <= n_t;

        // stage 10: round half up is floor((2*num + den) / (2*den))
        for (int i = 0; i < 3; i++) begin
            r10_x[i] <= ((XW'(r9_t[i][0]) + XW'(r9_t[i][1])) <<< 1) + XW'(r_den[9]);
        end
        r10_y <= YW'($unsigned(r_den[9])) << 1;

        for (int s = 8; s <= 10; s++) begin
            r_sel[s]  <= r_sel[s-1];
            r_base[s] <= r_base[s-1];
        end
        for (int s = 8; s <= 9; s++) begin
            r_den[s] <= r_den[s-1];
        end
    end

    // region tests, in priority order
    always_comb begin
        for (int j = 0; j < 6; j++) begin
            w_k_le0[j] = r_k[6][j][KW-1] || (r_k[6][j] == '0);
        end
        for (int n = 0; n < 3; n++) begin
            w_g_le0[n] = r6_g[n][GW-1] || (r6_g[n] == '0);
        end
        w_e43_le0 = r6_e43[EW-1] || (r6_e43 == '0);
        w_e56_le0 = r6_e56[EW-1] || (r6_e56 == '0);
        w_dint    = DW'(r6_g[GA]) + DW'(r6_g[GB]) + DW'(r6_g[GC]);

        n_sel.region   = REG_A;
        n_sel.use_base = 1'b1;
        n_sel.degen    = 1'b0;
        n_den          = '0;
        n_m[0]         = '0;
        n_m[1]         = '0;
        for (int i = 0; i < 3; i++) begin
            n_base[i] = $signed(r_geo[6].a[i]);
            n_u[0][i] = '0;
            n_u[1][i] = '0;
        end

        priority if (w_k_le0[K1] && w_k_le0[K2]) begin
            n_sel.region = REG_A;
        end else if (!r_k[6][K3][KW-1] && w_e43_le0) begin
            n_sel.region = REG_B;
            for (int i = 0; i < 3; i++) begin
                n_base[i] = $signed(r_geo[6].b[i]);
            end
        end else if (w_g_le0[GC] && !r_k[6][K1][KW-1] && w_k_le0[K3]) begin
            n_sel.region   = REG_AB;
            n_sel.use_base = r6_dab[EW-1] || (r6_dab == '0);
            n_den          = DW'(r6_dab);
            n_m[0]         = MW'(r_k[6][K1]);
            for (int i = 0; i < 3; i++) begin
                n_u[0][i] = $signed(r_geo[6].eab[i]);
            end
        end else if (!r_k[6][K6][KW-1] && w_e56_le0) begin
            n_sel.region = REG_C;
            for (int i = 0; i < 3; i++) begin
                n_base[i] = $signed(r_geo[6].c[i]);
            end
        end else if (w_g_le0[GB] && !r_k[6][K2][KW-1] && w_k_le0[K6]) begin
            n_sel.region   = REG_AC;
            n_sel.use_base = r6_dac[EW-1] || (r6_dac == '0);
            n_den          = DW'(r6_dac);
            n_m[0]         = MW'(r_k[6][K2]);
            for (int i = 0; i < 3; i++) begin
                n_u[0][i] = $signed(r_geo[6].eac[i]);
            end
        end else if (w_g_le0[GA] && !r6_e43[EW-1] && !r6_e56[EW-1]) begin
            n_sel.region   = REG_BC;
            n_sel.use_base = r6_dbc[EW-1] || (r6_dbc == '0);
            n_den          = DW'(r6_dbc);
            n_m[0]         = MW'(r6_e43);
            for (int i = 0; i < 3; i++) begin
                n_base[i] = $signed(r_geo[6].b[i]);
                n_u[0][i] = $signed(r_geo[6].ebc[i]);
            end
        end else begin
            // interior: offset = (eab*gb + eac*gc) / (ga+gb+gc)
            n_sel.region   = REG_IN;
            n_sel.use_base = w_dint[DW-1] || (w_dint == '0);
            n_sel.degen    = w_dint[DW-1] || (w_dint == '0);
            n_den          = w_dint;
            n_m[0]         = MW'(r6_g[GB]);
            n_m[1]         = MW'(r6_g[GC]);
            for (int i = 0; i < 3; i++) begin
                n_u[0][i] = $signed(r_geo[6].eab[i]);
                n_u[1][i] = $signed(r_geo[6].eac[i]);
            end
        end
    end

    // wide operand cut into unsigned chunks, top chunk signed
    always_comb begin
        for (int t = 0; t < 2; t++) begin
            w_me[t] = MEW'(r7_m[t]);
            for (int c = 0; c < NCH; c++) begin
                if (c < NCH-1) begin
                    w_ch[t][c] = $signed({1'b0, w_me[t][c*MC +: MC]});
                end else begin
                    w_ch[t][c] = $signed({w_me[t][MEW-1], w_me[t][c*MC +: MC]});
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int t = 0; t < 2; t++) begin
                n_t[i][t] = '0;
                for (int c = 0; c < NCH; c++) begin
                    n_t[i][t] = n_t[i][t] + (NW'(r8_pp[i][t][c]) <<< (MC*c));
                end
            end
        end
    end

    cpt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vld[10]),
        .i_sel   (r_sel[10]),
        .i_x     (r10_x),
        .i_y     (r10_y),
        .i_base  (r_base[10]),
        .o_vld   (o_done),
        .o_res   (o_result)
    );

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for closest_point_on_triangle_top: directed and random
// queries, each checked against an exact 256-bit closest-point calculation.
// Depends on cpt_pkg and the closest_point_on_triangle_top RTL.

class cpt_scoreboard;
    typedef logic signed [255:0] w_t;

    cpt_pkg::t_out_item pending[$];
    int errors = 0;

    function automatic w_t dot3(w_t u[3], w_t v[3]);
        return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
    endfunction

    // round half up of n/d, d > 0
    function automatic w_t round_ratio(w_t n, w_t d);
        w_t x, y, q;
        x = 2 * n + d;
        y = 2 * d;
        q = x / y;
        if (x < 0 && q * y != x) q = q - 1;
        return q;
    endfunction

    function automatic logic signed [31:0] clamp(w_t s);
        if (s > w_t'(cpt_pkg::CMAX)) return cpt_pkg::CMAX;
        if (s < w_t'(cpt_pkg::CMIN)) return cpt_pkg::CMIN;
        return s[31:0];
    endfunction

    function automatic cpt_pkg::t_out_item nearest(cpt_pkg::t_in_item it);
        w_t p[3], a[3], b[3], c[3], eab[3], eac[3], ebc[3], rp[3], rq[3], rc[3];
        w_t res[3], base[3], dir[3];
        w_t k1, k2, k3, k4, k5, k6, ga, gb, gc, num, den;
        int mode;
        cpt_pkg::t_region rgn;
        logic dg;
        cpt_pkg::t_out_item o;
        mode = 0;
        dg = 1'b0;
        num = 0;
        den = 0;
        p[0] = w_t'($signed(it.query_x));
        p[1] = w_t'($signed(it.query_y));
        p[2] = w_t'($signed(it.query_z));
        a[0] = w_t'($signed(it.vert_a_x));
        a[1] = w_t'($signed(it.vert_a_y));
        a[2] = w_t'($signed(it.vert_a_z));
        b[0] = w_t'($signed(it.vert_b_x));
        b[1] = w_t'($signed(it.vert_b_y));
        b[2] = w_t'($signed(it.vert_b_z));
        c[0] = w_t'($signed(it.vert_c_x));
        c[1] = w_t'($signed(it.vert_c_y));
        c[2] = w_t'($signed(it.vert_c_z));
        for (int i = 0; i < 3; i++) begin
            eab[i] = b[i] - a[i];
            eac[i] = c[i] - a[i];
            ebc[i] = c[i] - b[i];
            rp[i]  = p[i] - a[i];
            rq[i]  = p[i] - b[i];
            rc[i]  = p[i] - c[i];
            base[i] = a[i];
            dir[i]  = eab[i];
            res[i]  = a[i];
        end
        k1 = dot3(eab, rp);
        k2 = dot3(eac, rp);
        k3 = dot3(eab, rq);
        k4 = dot3(eac, rq);
        k5 = dot3(eab, rc);
        k6 = dot3(eac, rc);
        gc = k1 * k4 - k3 * k2;
        gb = k5 * k2 - k1 * k6;
        ga = k3 * k6 - k5 * k4;
        if (k1 <= 0 && k2 <= 0) begin
            rgn = cpt_pkg::REG_A;
        end else if (k3 >= 0 && k4 <= k3) begin
            rgn = cpt_pkg::REG_B;
            res = b;
        end else if (gc <= 0 && k1 >= 0 && k3 <= 0) begin
            rgn = cpt_pkg::REG_AB; mode = 1;
            num = k1; den = k1 - k3;
        end else if (k6 >= 0 && k5 <= k6) begin
            rgn = cpt_pkg::REG_C;
            res = c;
        end else if (gb <= 0 && k2 >= 0 && k6 <= 0) begin
            rgn = cpt_pkg::REG_AC; mode = 1;
            dir = eac;
            num = k2; den = k2 - k6;
        end else if (ga <= 0 && k4 - k3 >= 0 && k5 - k6 >= 0) begin
            rgn = cpt_pkg::REG_BC; mode = 1;
            base = b; dir = ebc;
            num = k4 - k3; den = num + (k5 - k6);
        end else begin
            rgn = cpt_pkg::REG_IN; mode = 2;
            den = ga + gb + gc;
        end
        if (mode == 1) begin
            for (int i = 0; i < 3; i++)
                res[i] = (den <= 0) ? base[i] : base[i] + round_ratio(dir[i] * num, den);
        end else if (mode == 2) begin
            if (den <= 0) dg = 1'b1;   // flat triangle: vertex A stands
            else
                for (int i = 0; i < 3; i++)
                    res[i] = a[i] + round_ratio(eab[i] * gb + eac[i] * gc, den);
        end
        o.near_x = clamp(res[0]);
        o.near_y = clamp(res[1]);
        o.near_z = clamp(res[2]);
        o.region = rgn;
        o.degenerate = dg;
        return o;
    endfunction

    function void note(cpt_pkg::t_in_item it);
        pending.push_back(nearest(it));
    endfunction

    function void check(cpt_pkg::t_out_item got);
        cpt_pkg::t_out_item exp_r;
        if (pending.size() == 0) begin
            $error("result with no query outstanding");
            errors++;
            return;
        end
        exp_r = pending.pop_front();
        if (got.near_x !== exp_r.near_x) begin
            $error("near_x expected %0d got %0d", exp_r.near_x, got.near_x); errors++;
        end
        if (got.near_y !== exp_r.near_y) begin
            $error("near_y expected %0d got %0d", exp_r.near_y, got.near_y); errors++;
        end
        if (got.near_z !== exp_r.near_z) begin
            $error("near_z expected %0d got %0d", exp_r.near_z, got.near_z); errors++;
        end
        if (got.region !== exp_r.region) begin
            $error("region expected %0d got %0d", exp_r.region, got.region); errors++;
        end
        if (got.degenerate !== exp_r.degenerate) begin
            $error("degenerate expected %0d got %0d", exp_r.degenerate, got.degenerate);
            errors++;
        end
    endfunction
endclass

module tb_top;
    import cpt_pkg::*;

    localparam int ONE = 65536;     // 1.0 in Q16.16
    localparam int N_RANDOM = 1800;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_start;
    t_in_item  i_item;
    logic      o_busy;
    logic      o_done;
    t_out_item o_result;

    cpt_scoreboard sb = new();

    closest_point_on_triangle_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_item   (i_item),
        .o_busy   (o_busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Monitor: values read here are the ones present before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && i_start && !o_busy) sb.note(i_item);
        if (i_rst_n && o_done) sb.check(o_result);
    end

    // Hard stop in case results never drain.
    initial begin
        #5ms;
        $display("closest_point_on_triangle_top verification failed");
        $finish;
    end

    // Drive one query; a random idle gap, possibly none, comes first.
    task automatic send_query(t_in_item it);
        int gap;
        gap = $urandom_range(0, 15);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    // Query built from whole units times ONE.
    function automatic t_in_item unit_query(int px, int py, int pz, int ax, int ay, int az,
                                            int bx, int by, int bz, int cx, int cy, int cz);
        t_in_item it;
        it = '{px * ONE, py * ONE, pz * ONE, ax * ONE, ay * ONE, az * ONE,
               bx * ONE, by * ONE, bz * ONE, cx * ONE, cy * ONE, cz * ONE};
        return it;
    endfunction

    // Coordinate in [-span, span+1) units, with random fraction bits.
    function automatic logic signed [31:0] near_coord(int span);
        return $signed($urandom_range(0, 2 * span)) * ONE - span * ONE
               + $signed({16'd0, 16'($urandom)});
    endfunction

    function automatic t_in_item random_query();
        t_in_item it;
        int kind, span, m;
        logic signed [31:0] d[3];
        kind = $urandom_range(0, 99);
        span = ($urandom_range(0, 3) == 0) ? 4000 : 60;
        if (kind < 25) begin
            // arbitrary bit patterns, full range
            it = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        end else if (kind < 40) begin
            // collinear or coincident vertices
            it.query_x = near_coord(span); it.query_y = near_coord(span);
            it.query_z = near_coord(span);
            it.vert_a_x = near_coord(span); it.vert_a_y = near_coord(span);
            it.vert_a_z = near_coord(span);
            for (int i = 0; i < 3; i++) d[i] = $signed($urandom_range(0, 8)) * ONE - 4 * ONE;
            m = $urandom_range(0, 3);
            case ($urandom_range(0, 2))
                0: begin
                    it.vert_b_x = it.vert_a_x + d[0]; it.vert_b_y = it.vert_a_y + d[1];
                    it.vert_b_z = it.vert_a_z + d[2];
                    it.vert_c_x = it.vert_a_x + m * d[0]; it.vert_c_y = it.vert_a_y + m * d[1];
                    it.vert_c_z = it.vert_a_z + m * d[2];
                end
                1: begin
                    it.vert_b_x = it.vert_a_x; it.vert_b_y = it.vert_a_y;
                    it.vert_b_z = it.vert_a_z;
                    it.vert_c_x = near_coord(span); it.vert_c_y = near_coord(span);
                    it.vert_c_z = near_coord(span);
                end
                default: begin
                    it.vert_b_x = near_coord(span); it.vert_b_y = near_coord(span);
                    it.vert_b_z = near_coord(span);
                    it.vert_c_x = it.vert_b_x; it.vert_c_y = it.vert_b_y;
                    it.vert_c_z = it.vert_b_z;
                end
            endcase
        end else begin
            it = '{near_coord(span), near_coord(span), near_coord(span),
                   near_coord(span), near_coord(span), near_coord(span),
                   near_coord(span), near_coord(span), near_coord(span),
                   near_coord(span), near_coord(span), near_coord(span)};
        end
        return it;
    endfunction

    initial begin
        t_in_item it;
        i_rst_n <= 1'b0;
        i_start <= 1'b0;
        i_item  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // One region each, triangle A(0,0,0) B(4,0,0) C(0,4,0); the last uses B(3,0,0) C(0,3,0).
        send_query(unit_query(-1, -1, 0, 0, 0, 0, 4, 0, 0, 0, 4, 0));  // vertex A
        send_query(unit_query(6, -1, 0, 0, 0, 0, 4, 0, 0, 0, 4, 0));   // vertex B
        send_query(unit_query(2, -2, 3, 0, 0, 0, 4, 0, 0, 0, 4, 0));   // edge AB
        send_query(unit_query(-1, 6, 0, 0, 0, 0, 4, 0, 0, 0, 4, 0));   // vertex C
        send_query(unit_query(-2, 2, 1, 0, 0, 0, 4, 0, 0, 0, 4, 0));   // edge AC
        send_query(unit_query(3, 3, 0, 0, 0, 0, 4, 0, 0, 0, 4, 0));    // edge BC
        send_query(unit_query(1, 1, 5, 0, 0, 0, 4, 0, 0, 0, 4, 0));    // interior
        send_query(unit_query(1, 1, -2, 0, 0, 0, 3, 0, 0, 0, 3, 0));   // interior, rounding
        // A == B: edge AB with zero length
        send_query(unit_query(1, 1, 0, 0, 0, 0, 0, 0, 0, 4, 0, 0));
        // B == C: the query lands in vertex region B
        send_query(unit_query(5, 5, 0, 0, 0, 0, 4, 0, 0, 4, 0, 0));
        // flat triangles
        send_query(unit_query(1, 0, 0, 0, 0, 0, 1, 1, 1, 2, 2, 2));
        send_query(unit_query(1, -1, 0, 0, 0, 0, 1, 1, 0, 2, 2, 0));
        send_query(unit_query(3, 3, 3, 2, 2, 2, 2, 2, 2, 2, 2, 2));
        // extremes of the coordinate range; several saturate
        it = '{default: CMAX};
        send_query(it);
        it = '{default: CMIN};
        send_query(it);
        it = '{CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMAX};
        send_query(it);
        it = '{CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN};
        send_query(it);
        it = '{CMAX, CMIN, 0, CMIN, CMAX, 0, CMAX, CMAX, 0, CMIN, CMIN, 0};
        send_query(it);
        it = '{0, 0, CMAX, CMIN, CMIN, 0, CMAX, CMIN, 0, CMIN, CMAX, 0};
        send_query(it);
        it = '{32'sd1, -32'sd1, 0, 0, 0, 0, CMAX, 0, 0, 0, CMIN, 0};
        send_query(it);

        for (int n = 0; n < N_RANDOM; n++) send_query(random_query());
        i_start <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("closest_point_on_triangle_top verification clean");
        end else begin
            $display("closest_point_on_triangle_top verification failed");
        end
        $finish;
    end
endmodule
